FILE: rtl/assert_macros.svh
// assertion macros used by the checker file
// no dependencies; include guard keeps a second include harmless
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising clock edge outside reset
`define PTB_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// same-cycle implication, antecedent and consequent given apart
`define PTB_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

FILE: rtl/ptb_pkg.sv
// shared types and register codes of the pitch trim bias observer
// no dependencies; imported by the core and the top level
package ptb_pkg;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 15;

    localparam logic [CFG_INDEX_W-1:0] REG_TRACK_ENABLE    = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_BIAS_LIMIT      = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_STEP_INITIAL    = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_STEP_MINIMUM    = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_FALL_THRESHOLD  = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_COAST_TICKS     = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_HOLD_SNAP_TICKS = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_ACCEL_LIMIT     = 3'd7;

    typedef struct packed {
        logic        track_enable;
        logic [14:0] bias_limit;
        logic [14:0] step_initial;
        logic [14:0] step_minimum;
        logic [14:0] fall_threshold;
        logic [7:0]  coast_ticks;
        logic [7:0]  hold_snap_ticks;
        logic [14:0] accel_limit;
    } ptb_cfg_t;

    typedef struct packed {
        logic               balancing;
        logic               holding;
        logic signed [15:0] pitch_command;
        logic signed [15:0] pitch;
        logic signed [15:0] wheel_velocity;
        logic signed [15:0] wheel_rate;
        logic signed [15:0] velocity_command;
        logic signed [15:0] half_torque;
    } ptb_in_t;

    // observer state of fixed width; window count and sum travel apart
    typedef struct packed {
        logic               command_seen;
        logic signed [15:0] last_command;
        logic signed [15:0] bias;
        logic               coasting;
        logic               held_before;
        logic [7:0]         quiet_count;
        logic [7:0]         hold_count;
        logic               rate_seen;
        logic signed [15:0] last_rate;
        logic signed [23:0] accel_filtered;
        logic signed [15:0] window_open_pitch;
        logic signed [15:0] bisect_step;
    } ptb_state_t;

endpackage

FILE: rtl/ptb_core.sv
// next-state and result logic for one item of the trim bias observer
// depends on ptb_pkg; purely combinational, registered by the top level
module ptb_core #(
    parameter int WINDOW_TICKS       = 64,
    parameter int VCMD_EPSILON       = 41,
    parameter int VELOCITY_MAX       = 410,
    parameter int RATE_MAX           = 2048,
    parameter int TORQUE_MAX         = 1024,
    parameter int ACCEL_FILTER_SHIFT = 3,
    localparam int LOG2_WIN          = $clog2(WINDOW_TICKS),
    localparam int CNT_W             = $clog2(WINDOW_TICKS + 1),
    localparam int SUM_W             = 16 + LOG2_WIN
) (
    input  ptb_pkg::ptb_cfg_t          cfg,
    input  ptb_pkg::ptb_in_t           item,
    input  ptb_pkg::ptb_state_t        st,
    input  logic [CNT_W-1:0]           window_count,
    input  logic signed [SUM_W-1:0]    pitch_sum,
    output ptb_pkg::ptb_state_t        st_next,
    output logic [CNT_W-1:0]           window_count_next,
    output logic signed [SUM_W-1:0]    pitch_sum_next,
    output logic signed [15:0]         result
);
    import ptb_pkg::*;

    localparam logic [16:0]        VCMD_C  = 17'(VCMD_EPSILON);
    localparam logic [16:0]        VEL_C   = 17'(VELOCITY_MAX);
    localparam logic [16:0]        RATE_C  = 17'(RATE_MAX);
    localparam logic signed [15:0] TORQ_C  = 16'(TORQUE_MAX);
    localparam logic [CNT_W-1:0]   WIN_C   = CNT_W'(WINDOW_TICKS);

    function automatic logic [16:0] mag17(input logic signed [15:0] v);
        logic signed [16:0] e;
        e = 17'(v);
        if (e < 0)
            mag17 = -e;
        else
            mag17 = e;
    endfunction

    function automatic logic signed [15:0] clamp_sym(input logic signed [17:0] v,
                                                      input logic [14:0] lim);
        logic signed [17:0] l;
        logic signed [17:0] nl;
        l  = {3'b000, lim};
        nl = -l;
        if (v > l)
            clamp_sym = l[15:0];
        else if (v < nl)
            clamp_sym = nl[15:0];
        else
            clamp_sym = v[15:0];
    endfunction

    always_comb
    begin
        logic                    cmd_clear;
        logic signed [16:0]      accel_raw;
        logic signed [24:0]      accel_diff;
        logic signed [24:0]      accel_sum;
        logic signed [24:0]      af_ext;
        logic [24:0]             af_mag;
        logic                    quiet;
        logic                    hold_start;
        logic [CNT_W-1:0]        wc_inc;
        logic signed [SUM_W-1:0] ps_inc;
        logic signed [SUM_W-1:0] mean_w;
        logic signed [15:0]      open_pitch;
        logic signed [16:0]      drift;
        logic signed [17:0]      drift_ext;
        logic [17:0]             drift_mag;
        logic                    want_neg;
        logic [16:0]             m;
        logic signed [17:0]      m_s;
        logic signed [17:0]      cap_s;
        logic signed [17:0]      step_w;
        logic signed [15:0]      step_cl;

        st_next           = st;
        window_count_next = window_count;
        pitch_sum_next    = pitch_sum;
        result            = '0;

        accel_raw  = 17'(item.wheel_rate) - 17'(st.last_rate);
        accel_diff = 25'(accel_raw) - 25'(st.accel_filtered);
        accel_sum  = 25'(st.accel_filtered) + (accel_diff >>> ACCEL_FILTER_SHIFT);
        af_ext     = '0;
        af_mag     = '0;
        quiet      = 1'b0;
        hold_start = 1'b0;
        wc_inc     = '0;
        ps_inc     = '0;
        mean_w     = '0;
        open_pitch = st.window_open_pitch;
        drift      = '0;
        drift_ext  = '0;
        drift_mag  = '0;
        want_neg   = 1'b0;
        m          = '0;
        m_s        = '0;
        cap_s      = {3'b000, cfg.step_initial};
        step_w     = '0;
        step_cl    = '0;

        // command change clears bias, window and step, even while resting
        cmd_clear = st.command_seen && (item.pitch_command != st.last_command);
        st_next.command_seen = 1'b1;
        st_next.last_command = item.pitch_command;
        if (cmd_clear)
        begin
            st_next.bias        = '0;
            st_next.bisect_step = '0;
            window_count_next   = '0;
            pitch_sum_next      = '0;
        end

        if (!item.balancing)
        begin
            st_next.bias           = '0;
            st_next.coasting       = 1'b0;
            st_next.held_before    = 1'b0;
            st_next.quiet_count    = '0;
            st_next.hold_count     = '0;
            st_next.accel_filtered = '0;
            st_next.rate_seen      = 1'b0;
            st_next.bisect_step    = '0;
            window_count_next      = '0;
            pitch_sum_next         = '0;
        end
        else
        begin
            // acceleration filter; first tick only loads the rate
            st_next.last_rate = item.wheel_rate;
            st_next.rate_seen = 1'b1;
            if (!st.rate_seen)
                st_next.accel_filtered = '0;
            else
                st_next.accel_filtered = accel_sum[23:0];

            if (!cfg.track_enable)
            begin
                st_next.coasting    = 1'b0;
                st_next.held_before = item.holding;
            end
            else
            begin
                if (!item.holding)
                    st_next.hold_count = '0;

                af_ext = 25'(st_next.accel_filtered);
                af_mag = (af_ext < 0) ? -af_ext : af_ext;
                quiet  = !item.holding
                         && (mag17(item.velocity_command) < VCMD_C)
                         && (mag17(item.wheel_velocity) < VEL_C)
                         && (mag17(item.wheel_rate) < RATE_C)
                         && (af_mag < {10'd0, cfg.accel_limit})
                         && (item.half_torque < TORQ_C);

                // quiet counter with hysteresis
                if (item.holding)
                    st_next.quiet_count = cfg.coast_ticks;
                else if (quiet)
                begin
                    if (st.quiet_count < cfg.coast_ticks)
                        st_next.quiet_count = st.quiet_count + 8'd1;
                end
                else if (st.quiet_count != 8'd0)
                    st_next.quiet_count = st.quiet_count - 8'd1;

                st_next.coasting    = item.holding
                                      || (st_next.quiet_count >= cfg.coast_ticks);
                hold_start          = item.holding && !st.held_before;
                st_next.held_before = item.holding;

                if (hold_start || (st_next.coasting && !st.coasting))
                begin
                    window_count_next   = '0;
                    pitch_sum_next      = '0;
                    st_next.bisect_step = '0;
                end
                else if (!st_next.coasting)
                begin
                    window_count_next = '0;
                    pitch_sum_next    = '0;
                end
                else
                begin
                    if (window_count_next == '0)
                        open_pitch = item.pitch;
                    st_next.window_open_pitch = open_pitch;
                    wc_inc = window_count_next + CNT_W'(1);
                    ps_inc = pitch_sum_next + SUM_W'(item.pitch);

                    if (wc_inc >= WIN_C)
                    begin
                        // window closes: snap or bisection step
                        mean_w = ps_inc >>> LOG2_WIN;
                        if (item.holding && (st_next.hold_count < cfg.hold_snap_ticks))
                            st_next.hold_count = st_next.hold_count + 8'd1;

                        drift     = 17'(item.pitch) - 17'(open_pitch);
                        drift_ext = 18'(drift);
                        drift_mag = (drift_ext < 0) ? -drift_ext : drift_ext;

                        if (drift_mag < {3'b000, cfg.fall_threshold})
                        begin
                            if (item.holding && (st_next.hold_count >= cfg.hold_snap_ticks))
                            begin
                                st_next.bias = clamp_sym(18'(mean_w)
                                                         - 18'(item.pitch_command),
                                                         cfg.bias_limit);
                                st_next.bisect_step = '0;
                            end
                        end
                        else
                        begin
                            want_neg = (drift > 0);
                            if (st_next.bisect_step == '0)
                                step_w = want_neg ? -cap_s : cap_s;
                            else if ((st_next.bisect_step > 0) == want_neg)
                            begin
                                // direction flips: halve, keep at least the minimum
                                m = mag17(st_next.bisect_step) >> 1;
                                if (m < {2'b00, cfg.step_minimum})
                                    m = {2'b00, cfg.step_minimum};
                                m_s    = {1'b0, m};
                                step_w = want_neg ? -m_s : m_s;
                            end
                            else
                                step_w = 18'(st_next.bisect_step);
                            step_cl             = clamp_sym(step_w, cfg.step_initial);
                            st_next.bisect_step = step_cl;
                            st_next.bias        = clamp_sym(18'(st_next.bias) + 18'(step_cl),
                                                            cfg.bias_limit);
                        end
                        window_count_next = '0;
                        pitch_sum_next    = '0;
                    end
                    else
                    begin
                        window_count_next = wc_inc;
                        pitch_sum_next    = ps_inc;
                    end
                end
                result = st_next.bias;
            end
        end
    end

endmodule

FILE: rtl/pitch_trim_bias_observer_unit.sv
// top level of the pitch trim bias observer: handshakes, registers, config
// depends on ptb_pkg and ptb_core
// flow: an accepted item sits in the input register and moves to the result
//   register once that is empty or being taken; out_valid rises as it moves
// throughput: one item per cycle; in_stall rises only when both registers are
//   full and the result is stalled
// reset (rst_n low, asynchronous) clears the observer state, empties both
//   registers and loads the register defaults; there is no clearing pass
module pitch_trim_bias_observer_unit #(
    parameter int WINDOW_TICKS       = 64,    // averaging window, power of two
    parameter int VCMD_EPSILON       = 41,
    parameter int VELOCITY_MAX       = 410,
    parameter int RATE_MAX           = 2048,
    parameter int TORQUE_MAX         = 1024,
    parameter int ACCEL_FILTER_SHIFT = 3
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // input item channel
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic                               balancing,
    input  logic                               holding,
    input  logic signed [15:0]                 pitch_command,
    input  logic signed [15:0]                 pitch,
    input  logic signed [15:0]                 wheel_velocity,
    input  logic signed [15:0]                 wheel_rate,
    input  logic signed [15:0]                 velocity_command,
    input  logic signed [15:0]                 half_torque,
    // result item channel
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic signed [15:0]                 trim_bias,
    // register write port
    input  logic                               cfg_write,
    input  logic [ptb_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [ptb_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import ptb_pkg::*;

    localparam int LOG2_WIN = $clog2(WINDOW_TICKS);
    localparam int CNT_W    = $clog2(WINDOW_TICKS + 1);
    localparam int SUM_W    = 16 + LOG2_WIN;

    // configuration registers
    ptb_cfg_t cfg_reg;

    // input register: one item waiting for the result register
    logic     in_valid_reg;
    ptb_in_t  item_reg;

    // result register
    logic               out_valid_reg;
    logic signed [15:0] trim_bias_reg;

    // observer state
    ptb_state_t              st_reg;
    ptb_state_t              st_next;
    logic [CNT_W-1:0]        window_count_reg;
    logic [CNT_W-1:0]        window_count_next;
    logic signed [SUM_W-1:0] pitch_sum_reg;
    logic signed [SUM_W-1:0] pitch_sum_next;
    logic signed [15:0]      result;

    logic advance;
    logic in_accept;

    // item moves on when the result register is empty or being taken
    assign advance   = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = in_valid_reg && !advance;
    assign in_accept = in_valid && !in_stall;

    assign out_valid = out_valid_reg;
    assign trim_bias = trim_bias_reg;

    ptb_core #(
        .WINDOW_TICKS       (WINDOW_TICKS),
        .VCMD_EPSILON       (VCMD_EPSILON),
        .VELOCITY_MAX       (VELOCITY_MAX),
        .RATE_MAX           (RATE_MAX),
        .TORQUE_MAX         (TORQUE_MAX),
        .ACCEL_FILTER_SHIFT (ACCEL_FILTER_SHIFT)
    ) u_core (
        .cfg               (cfg_reg),
        .item              (item_reg),
        .st                (st_reg),
        .window_count      (window_count_reg),
        .pitch_sum         (pitch_sum_reg),
        .st_next           (st_next),
        .window_count_next (window_count_next),
        .pitch_sum_next    (pitch_sum_next),
        .result            (result)
    );

    // register writes; the user must write only while the block is idle, not enforced here
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.track_enable    <= 1'b1;
            cfg_reg.bias_limit      <= 15'd410;
            cfg_reg.step_initial    <= 15'd41;
            cfg_reg.step_minimum    <= 15'd4;
            cfg_reg.fall_threshold  <= 15'd82;
            cfg_reg.coast_ticks     <= 8'd50;
            cfg_reg.hold_snap_ticks <= 8'd20;
            cfg_reg.accel_limit     <= 15'd200;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_TRACK_ENABLE:    cfg_reg.track_enable    <= cfg_data[0];
                REG_BIAS_LIMIT:      cfg_reg.bias_limit      <= cfg_data;
                REG_STEP_INITIAL:    cfg_reg.step_initial    <= cfg_data;
                REG_STEP_MINIMUM:    cfg_reg.step_minimum    <= cfg_data;
                REG_FALL_THRESHOLD:  cfg_reg.fall_threshold  <= cfg_data;
                REG_COAST_TICKS:     cfg_reg.coast_ticks     <= cfg_data[7:0];
                REG_HOLD_SNAP_TICKS: cfg_reg.hold_snap_ticks <= cfg_data[7:0];
                REG_ACCEL_LIMIT:     cfg_reg.accel_limit     <= cfg_data;
                default:             cfg_reg                 <= cfg_reg;
            endcase
        end
    end

    // handshake control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_accept)
                in_valid_reg <= 1'b1;
            else if (advance)
                in_valid_reg <= 1'b0;

            if (advance)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            item_reg.balancing        <= balancing;
            item_reg.holding          <= holding;
            item_reg.pitch_command    <= pitch_command;
            item_reg.pitch            <= pitch;
            item_reg.wheel_velocity   <= wheel_velocity;
            item_reg.wheel_rate       <= wheel_rate;
            item_reg.velocity_command <= velocity_command;
            item_reg.half_torque      <= half_torque;
        end
        if (advance)
            trim_bias_reg <= result;
    end

    // observer state moves with the item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg           <= '0;
            window_count_reg <= '0;
            pitch_sum_reg    <= '0;
        end
        else if (advance)
        begin
            st_reg           <= st_next;
            window_count_reg <= window_count_next;
            pitch_sum_reg    <= pitch_sum_next;
        end
    end

endmodule

FILE: rtl/ptb_checker.sv
// port-level checks of the pitch trim bias observer, bound to the top level
// depends on assert_macros.svh and pitch_trim_bias_observer_unit
`include "assert_macros.svh"

module ptb_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_stall,
    input logic               out_valid,
    input logic               out_stall,
    input logic signed [15:0] trim_bias
);
    logic [1:0] inflight_reg;
    logic [1:0] inflight_next;
    logic       in_acc;
    logic       out_acc;

    assign in_acc        = in_valid && !in_stall;
    assign out_acc       = out_valid && !out_stall;
    assign inflight_next = inflight_reg + {1'b0, in_acc} - {1'b0, out_acc};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            inflight_reg <= '0;
        else
            inflight_reg <= inflight_next;
    end

    // a waiting result holds still
    `PTB_ASSERT_IMPLY(a_out_hold, clk, rst_n, out_valid && out_stall, ##1 (out_valid && $stable(trim_bias)), "result changed while stalled")
    // input stalls only behind a result that is itself stalled
    `PTB_ASSERT_IMPLY(a_stall_cause, clk, rst_n, in_stall, out_valid && out_stall, "input stalled without output back-pressure")
    // never more than the input and result registers hold
    `PTB_ASSERT(a_inflight_max, clk, rst_n, inflight_reg != 2'd3, "more items in flight than registers")
    // no result without an item behind it
    `PTB_ASSERT_IMPLY(a_no_invent, clk, rst_n, out_acc, inflight_reg != 2'd0, "result delivered with no item in flight")
    // an item into an empty block passes the input register, then shows its result
    `PTB_ASSERT_IMPLY(a_latency, clk, rst_n, in_acc && (inflight_reg == 2'd0), ##2 out_valid, "result missing two cycles after accept")

endmodule

bind pitch_trim_bias_observer_unit ptb_checker u_ptb_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .trim_bias (trim_bias)
);
